FILE: hw/rtl/crfm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package crfm_pkg;
    localparam int ENTRIES = 32;
    localparam int IDX_W = 5;
    localparam int ID_W = 29;
    localparam int DATA_W = 64;
    localparam int AGE_W = 8;
    localparam int CNT_W = 6;
    localparam int FRAME_BYTES = 8;
    localparam logic [AGE_W-1:0] DEFAULT_STALE_LIMIT = 8'd100;
    localparam int QDEPTH = 2;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_FRAME = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    // classified request passed from front to back
    typedef struct packed {
        cmd_t              cmd;
        logic [IDX_W-1:0]  idx;
        logic [ID_W-1:0]   id;
        logic              enable;
        logic [DATA_W-1:0] payload;
        logic [DATA_W-1:0] mask;
        logic              refresh;
    } req_t;

    typedef struct packed {
        logic              hit;
        logic [IDX_W-1:0]  hit_index;
        logic [DATA_W-1:0] entry_data;
        logic [AGE_W-1:0]  entry_age;
        logic [CNT_W-1:0]  stale_entries;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SCAN, ST_RD, ST_TICK, ST_CAP, ST_OUT
    } state_t;
endpackage
`default_nettype wire

FILE: hw/rtl/crfm_front.sv
`timescale 1ns / 1ps
`default_nettype none
module crfm_front (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [1:0]           cmd,
    input  wire logic [4:0]           entry_index,
    input  wire logic [28:0]          extended_id,
    input  wire logic [10:0]          standard_id,
    input  wire logic                 is_extended,
    input  wire logic [3:0]           byte_count,
    input  wire logic [63:0]          payload,
    input  wire logic                 refresh_age,
    input  wire logic                 entry_enable,
    output logic                      q_valid,
    input  wire logic                 q_ready,
    output crfm_pkg::req_t            q_req
);
    crfm_pkg::req_t q_reg [crfm_pkg::QDEPTH];
    logic [0:0] wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    crfm_pkg::req_t r;
    logic push, pop;

    always_comb begin
        r.cmd = crfm_pkg::cmd_t'(cmd);
        r.idx = entry_index;
        r.id = (is_extended || r.cmd == crfm_pkg::CMD_LOAD) ? extended_id
                                                             : {18'd0, standard_id};
        r.enable = entry_enable;
        r.payload = payload;
        r.refresh = refresh_age;
        if (byte_count >= 4'(crfm_pkg::FRAME_BYTES)) begin
            r.mask = '1;
        end else begin
            r.mask = ~({64{1'b1}} << {byte_count[2:0], 3'b000});
        end
    end

    assign in_ready = cnt_reg != 2'(crfm_pkg::QDEPTH);
    assign push = in_valid && in_ready;
    assign q_valid = cnt_reg != 2'd0;
    assign pop = q_valid && q_ready;
    assign q_req = q_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wp_reg] <= r;
        end
        if (!aresetn) begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= wp_reg + 1'b1;
            if (pop) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end
endmodule
`default_nettype wire

FILE: hw/rtl/crfm_back.sv
`timescale 1ns / 1ps
`default_nettype none
module crfm_back (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic [7:0]       stale_limit,
    input  wire logic             q_valid,
    output logic                  q_ready,
    input  crfm_pkg::req_t        q_req,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output crfm_pkg::rsp_t        out_rsp
);
    // filter ids and valids in flops (parallel-free scan, one per cycle);
    // data and ages in memories
    logic [crfm_pkg::ID_W-1:0]   fid_reg [crfm_pkg::ENTRIES];
    logic [crfm_pkg::ENTRIES-1:0] fval_reg;
    logic [crfm_pkg::DATA_W-1:0] data_mem [crfm_pkg::ENTRIES];
    logic [crfm_pkg::AGE_W-1:0]  age_mem [crfm_pkg::ENTRIES];
    // flags mark entries written since reset; unwritten entries read as zero
    logic [crfm_pkg::ENTRIES-1:0] dwr_reg, awr_reg;

    crfm_pkg::state_t state_reg, state_next;
    crfm_pkg::req_t   req_reg;
    crfm_pkg::rsp_t   rsp_reg, rsp_next;
    logic [crfm_pkg::IDX_W:0] ptr_reg, ptr_next;
    logic [crfm_pkg::IDX_W-1:0] p;
    logic [crfm_pkg::DATA_W-1:0] rd_data;
    logic [crfm_pkg::AGE_W-1:0]  rd_age;
    logic take, d_we, a_we;
    logic [crfm_pkg::DATA_W-1:0] d_wd;
    logic [crfm_pkg::AGE_W-1:0]  a_wd;

    assign p = ptr_reg[crfm_pkg::IDX_W-1:0];
    assign q_ready = state_reg == crfm_pkg::ST_IDLE;
    assign take = q_valid && q_ready;
    assign out_valid = state_reg == crfm_pkg::ST_OUT;
    assign out_rsp = rsp_reg;

    always_ff @(posedge aclk) begin
        rd_data <= dwr_reg[p] ? data_mem[p] : '0;
        rd_age  <= awr_reg[p] ? age_mem[p] : '0;
        if (d_we) data_mem[p] <= d_wd;
        if (a_we) age_mem[p] <= a_wd;
        if (take) req_reg <= q_req;
        rsp_reg <= rsp_next;
        if (take && q_req.cmd == crfm_pkg::CMD_LOAD) begin
            fid_reg[q_req.idx] <= q_req.id;
        end
        if (!aresetn) begin
            state_reg <= crfm_pkg::ST_IDLE;
            ptr_reg <= '0;
            fval_reg <= '0;
            dwr_reg <= '0;
            awr_reg <= '0;
        end else begin
            state_reg <= state_next;
            ptr_reg <= ptr_next;
            if (take && q_req.cmd == crfm_pkg::CMD_LOAD) begin
                fval_reg[q_req.idx] <= q_req.enable;
            end
            if (d_we) dwr_reg[p] <= 1'b1;
            if (a_we) awr_reg[p] <= 1'b1;
        end
    end

    // tick: two-phase per entry (read, then update)
    always_comb begin
        state_next = state_reg;
        ptr_next = ptr_reg;
        rsp_next = rsp_reg;
        d_we = 1'b0;
        a_we = 1'b0;
        d_wd = '0;
        a_wd = '0;
        unique case (state_reg)
            crfm_pkg::ST_IDLE: begin
                rsp_next = '0;
                ptr_next = '0;
                if (take) begin
                    unique case (q_req.cmd)
                        crfm_pkg::CMD_LOAD:  state_next = crfm_pkg::ST_OUT;
                        crfm_pkg::CMD_FRAME: state_next = crfm_pkg::ST_SCAN;
                        crfm_pkg::CMD_TICK:  state_next = crfm_pkg::ST_RD;
                        crfm_pkg::CMD_READ: begin
                            ptr_next = {1'b0, q_req.idx};
                            state_next = crfm_pkg::ST_RD;
                        end
                        default: state_next = crfm_pkg::ST_OUT;
                    endcase
                end
            end
            crfm_pkg::ST_SCAN: begin
                if (fval_reg[p] && fid_reg[p] == req_reg.id) begin
                    rsp_next.hit = 1'b1;
                    rsp_next.hit_index = p;
                    state_next = crfm_pkg::ST_RD;
                end else if (ptr_reg == 6'(crfm_pkg::ENTRIES - 1)) begin
                    state_next = crfm_pkg::ST_OUT;
                end else begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            crfm_pkg::ST_RD: begin
                // read data registered this cycle
                state_next = (req_reg.cmd == crfm_pkg::CMD_READ) ? crfm_pkg::ST_CAP
                                                                  : crfm_pkg::ST_TICK;
            end
            crfm_pkg::ST_TICK: begin
                if (req_reg.cmd == crfm_pkg::CMD_FRAME) begin
                    d_we = 1'b1;
                    d_wd = (rd_data & ~req_reg.mask) | (req_reg.payload & req_reg.mask);
                    a_we = req_reg.refresh;
                    a_wd = '0;
                    state_next = crfm_pkg::ST_OUT;
                end else begin
                    if (rd_age > stale_limit) begin
                        d_we = 1'b1;
                        d_wd = '0;
                        rsp_next.stale_entries = rsp_reg.stale_entries + 1'b1;
                    end else if (rd_age != 8'hFF) begin
                        a_we = 1'b1;
                        a_wd = rd_age + 1'b1;
                    end
                    if (ptr_reg == 6'(crfm_pkg::ENTRIES - 1)) begin
                        state_next = crfm_pkg::ST_OUT;
                    end else begin
                        ptr_next = ptr_reg + 1'b1;
                        state_next = crfm_pkg::ST_RD;
                    end
                end
            end
            crfm_pkg::ST_CAP: begin
                rsp_next.entry_data = rd_data;
                rsp_next.entry_age = rd_age;
                state_next = crfm_pkg::ST_OUT;
            end
            crfm_pkg::ST_OUT: begin
                if (out_ready) begin
                    state_next = crfm_pkg::ST_IDLE;
                end
            end
            default: state_next = crfm_pkg::ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

FILE: hw/rtl/can_rx_filter_mailbox_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// CAN receive mailbox: 32 identifier filters with per-entry data and age.
// One result per request. A frame does a sequential identifier scan (one
// entry per cycle), then on a hit a read-modify-write of the data memory; a
// tick reads and then updates each entry in turn through the single-port
// data and age memories. A two-entry request queue lets the input side run
// ahead of the back end.
module can_rx_filter_mailbox_unit (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [0:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // cmd[1:0] entry_index[6:2] extended_id[35:7] standard_id[46:36]
    // is_extended[47] byte_count[51:48] payload[115:52] refresh_age[116]
    // entry_enable[117], zero to 119
    input  wire logic [119:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // hit[0] hit_index[5:1] entry_data[69:6] entry_age[77:70]
    // stale_entries[83:78], zero to 87
    output logic [87:0]       m_tdata
);
    logic [7:0] limit_reg;
    logic q_valid, q_ready;
    crfm_pkg::req_t q_req;
    crfm_pkg::rsp_t rsp;

    assign pready = 1'b1;
    assign prdata = (paddr == 1'b0) ? {24'd0, limit_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= crfm_pkg::DEFAULT_STALE_LIMIT;
        end else if (psel && penable && pwrite && paddr == 1'b0) begin
            limit_reg <= pwdata[7:0];
        end
    end

    crfm_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .cmd(s_tdata[1:0]), .entry_index(s_tdata[6:2]),
        .extended_id(s_tdata[35:7]), .standard_id(s_tdata[46:36]),
        .is_extended(s_tdata[47]), .byte_count(s_tdata[51:48]),
        .payload(s_tdata[115:52]), .refresh_age(s_tdata[116]),
        .entry_enable(s_tdata[117]),
        .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
    );

    crfm_back u_back (
        .aclk(aclk), .aresetn(aresetn), .stale_limit(limit_reg),
        .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_rsp(rsp)
    );

    assign m_tdata = {4'd0, rsp.stale_entries, rsp.entry_age, rsp.entry_data,
                      rsp.hit_index, rsp.hit};
endmodule
`default_nettype wire

FILE: bench/testbench.sv
`timescale 1ns / 1ps
module testbench;
    typedef struct {
        logic [1:0]  cmd;
        logic [4:0]  idx;
        logic [28:0] ext_id;
        logic [10:0] std_id;
        logic        is_ext;
        logic [3:0]  nbytes;
        logic [63:0] payload;
        logic        refresh;
        logic        enable;
    } request_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [0:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [119:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [87:0]  m_tdata;

    can_rx_filter_mailbox_unit dut (.*);

    // predictor state
    logic [28:0] flt_id [crfm_pkg::ENTRIES];
    logic        flt_on [crfm_pkg::ENTRIES];
    logic [63:0] mbox   [crfm_pkg::ENTRIES];
    logic [7:0]  age    [crfm_pkg::ENTRIES];
    logic [7:0]  limit;

    request_t     pending_requests[$];
    logic [87:0]  expected_responses[$];
    int           errors = 0;
    int           send_idle_pct = 16, recv_idle_pct = 50;

    initial begin
        forever #10 aclk = ~aclk;
    end

    task automatic report(input string what, input logic [87:0] got, input logic [87:0] exp);
        $display("mismatch %s: got %h expected %h at %0t", what, got, exp, $realtime);
        errors++;
    endtask

    function automatic logic [119:0] pack_request(input request_t r);
        return {2'b0, r.enable, r.refresh, r.payload, r.nbytes, r.is_ext, r.std_id,
                r.ext_id, r.idx, r.cmd};
    endfunction

    function automatic logic [87:0] mailbox_response(input request_t r);
        logic        hit;
        logic [4:0]  hidx;
        logic [63:0] data, m;
        logic [7:0]  a;
        logic [5:0]  stale;
        logic [28:0] id;
        hit = 0; hidx = 0; data = 0; a = 0; stale = 0;
        case (crfm_pkg::cmd_t'(r.cmd))
            crfm_pkg::CMD_LOAD: begin
                flt_id[r.idx] = r.ext_id;
                flt_on[r.idx] = r.enable;
            end
            crfm_pkg::CMD_FRAME: begin
                id = r.is_ext ? r.ext_id : {18'b0, r.std_id};
                m = (r.nbytes >= 8) ? '1 : ((64'd1 << (8 * r.nbytes)) - 1);
                for (int i = 0; i < crfm_pkg::ENTRIES; i++) begin
                    if (!hit && flt_on[i] && flt_id[i] == id) begin
                        mbox[i] = (mbox[i] & ~m) | (r.payload & m);
                        if (r.refresh) age[i] = 0;
                        hit = 1;
                        hidx = 5'(i);
                    end
                end
            end
            crfm_pkg::CMD_TICK: begin
                for (int i = 0; i < crfm_pkg::ENTRIES; i++) begin
                    if (age[i] > limit) begin
                        mbox[i] = 0;
                        stale++;
                    end else if (age[i] != 8'hff) begin
                        age[i]++;
                    end
                end
            end
            default: begin
                data = mbox[r.idx];
                a = age[r.idx];
            end
        endcase
        return {4'b0, stale, a, data, hidx, hit};
    endfunction

    // driver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || s_tready) begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    expected_responses.push_back(mailbox_response(pending_requests[0]));
                    s_tdata <= pack_request(pending_requests.pop_front());
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_responses.size() == 0) begin
                    report("unexpected response", m_tdata, '0);
                end else begin
                    logic [87:0] e;
                    e = expected_responses.pop_front();
                    if (m_tdata[0] !== e[0]) report("hit", m_tdata, e);
                    if (m_tdata[5:1] !== e[5:1]) report("hit_index", m_tdata, e);
                    if (m_tdata[69:6] !== e[69:6]) report("entry_data", m_tdata, e);
                    if (m_tdata[77:70] !== e[77:70]) report("entry_age", m_tdata, e);
                    if (m_tdata[83:78] !== e[83:78]) report("stale_entries", m_tdata, e);
                    if (m_tdata[87:84] !== e[87:84]) report("padding", m_tdata, e);
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic write_limit(input logic [7:0] v);
        @(posedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= '0; pwdata <= {24'b0, v};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        limit = v;
    endtask

    task automatic drain();
        while (pending_requests.size() != 0 || s_tvalid || expected_responses.size() != 0)
            @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    function automatic request_t random_request(input int cmd_w);
        request_t r;
        r.cmd = 2'(cmd_w);
        r.idx = 5'($urandom);
        r.ext_id = 29'($urandom);
        r.std_id = 11'($urandom);
        r.is_ext = 1'($urandom);
        r.nbytes = ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(8));
        r.payload = {$urandom, $urandom};
        r.refresh = 1'($urandom);
        r.enable = ($urandom_range(4) != 0);
        return r;
    endfunction

    // a frame aimed at one of the filter identifiers most of the time
    function automatic request_t random_frame();
        request_t r;
        int k;
        r = random_request(crfm_pkg::CMD_FRAME);
        if ($urandom_range(9) < 8) begin
            k = int'($urandom_range(crfm_pkg::ENTRIES - 1));
            if (flt_id[k] < 2048 && $urandom_range(1)) begin
                r.is_ext = 0;
                r.std_id = 11'(flt_id[k]);
            end else begin
                r.is_ext = 1;
                r.ext_id = flt_id[k];
            end
        end
        return r;
    endfunction

    task automatic random_phase(input int n);
        int c;
        for (int i = 0; i < n; i++) begin
            c = int'($urandom_range(99));
            if (c < 15) pending_requests.push_back(random_request(crfm_pkg::CMD_LOAD));
            else if (c < 60) pending_requests.push_back(random_frame());
            else if (c < 75) pending_requests.push_back(random_request(crfm_pkg::CMD_TICK));
            else pending_requests.push_back(random_request(crfm_pkg::CMD_READ));
        end
    endtask

    initial begin
        request_t r;
        for (int i = 0; i < crfm_pkg::ENTRIES; i++) begin
            flt_id[i] = 0; flt_on[i] = 0; mbox[i] = 0; age[i] = 0;
        end
        limit = crfm_pkg::DEFAULT_STALE_LIMIT;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, duplicate filters, short and long frames
        r = random_request(crfm_pkg::CMD_READ); r.idx = 5'd31; pending_requests.push_back(r);
        r = random_request(crfm_pkg::CMD_LOAD); r.idx = 5'd0; r.ext_id = '1; r.enable = 1;
        pending_requests.push_back(r);
        r = random_request(crfm_pkg::CMD_LOAD); r.idx = 5'd31; r.ext_id = 29'h7ff;
        r.enable = 1;
        pending_requests.push_back(r);
        r = random_request(crfm_pkg::CMD_LOAD); r.idx = 5'd5; r.ext_id = 29'h7ff;
        r.enable = 1;
        pending_requests.push_back(r);
        r = random_request(crfm_pkg::CMD_LOAD); r.idx = 5'd6; r.ext_id = 29'h123;
        r.enable = 0;
        pending_requests.push_back(r);
        r = random_request(crfm_pkg::CMD_FRAME); r.is_ext = 1; r.ext_id = '1; r.nbytes = 4'd15;
        r.payload = '1; r.refresh = 1; pending_requests.push_back(r);
        r = random_request(crfm_pkg::CMD_FRAME); r.is_ext = 0; r.std_id = 11'h7ff;
        r.nbytes = 4'd3;
        r.refresh = 0; pending_requests.push_back(r);
        r = random_request(crfm_pkg::CMD_FRAME); r.is_ext = 0; r.std_id = 11'h7ff;
        r.nbytes = 4'd0;
        r.refresh = 1; pending_requests.push_back(r);
        r = random_request(crfm_pkg::CMD_FRAME); r.is_ext = 1; r.ext_id = 29'h123;
        pending_requests.push_back(r);
        r = random_request(crfm_pkg::CMD_FRAME); r.is_ext = 1; r.ext_id = 0; r.payload = 0;
        pending_requests.push_back(r);
        r = random_request(crfm_pkg::CMD_TICK); pending_requests.push_back(r);
        for (int i = 0; i < 4; i++) begin
            r = random_request(crfm_pkg::CMD_READ);
            r.idx = (i == 0) ? 5'd0 : (i == 1) ? 5'd5 : (i == 2) ? 5'd31 : 5'd6;
            pending_requests.push_back(r);
        end
        drain();

        // limit zero: entries go stale after one tick
        write_limit(8'd0);
        for (int i = 0; i < 3; i++)
            pending_requests.push_back(random_request(crfm_pkg::CMD_TICK));
        random_phase(600);
        drain();

        send_idle_pct = 50; recv_idle_pct = 16;
        write_limit(8'd255);
        // long tick run to reach the age ceiling
        for (int i = 0; i < 260; i++)
            pending_requests.push_back(random_request(crfm_pkg::CMD_TICK));
        for (int i = 0; i < crfm_pkg::ENTRIES; i++) begin
            r = random_request(crfm_pkg::CMD_READ); r.idx = 5'(i); pending_requests.push_back(r);
        end
        random_phase(300);
        drain();

        send_idle_pct = 0; recv_idle_pct = 0;
        write_limit(8'd3);
        random_phase(700);
        drain();
        write_limit(8'd254);
        random_phase(200);
        drain();

        if (errors == 0) begin
            $display("can_rx_filter_mailbox_unit regression: pass");
        end else begin
            $display("can_rx_filter_mailbox_unit regression: fail");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("can_rx_filter_mailbox_unit regression: fail");
        $finish;
    end
endmodule

FILE: files.f
hw/rtl/crfm_pkg.sv
hw/rtl/crfm_front.sv
hw/rtl/crfm_back.sv
hw/rtl/can_rx_filter_mailbox_unit.sv
bench/testbench.sv
